// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the tilt smoother RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property must hold at every clock outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition must never be seen outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`endif

// ----- rtl/tas_pkg.sv -----
// Package: types, constants and arctangent table for the tilt smoother
`timescale 1ns / 1ps
package tas_pkg;
  localparam int CordicIterDefault = 16;
  localparam int SqrtSteps         = 24;
  localparam int WeightReset       = 205;
  localparam int AtanEntries       = 24;

  typedef enum logic [2:0] {
    LS_IDLE, LS_SQ1, LS_SQ2, LS_SQRT, LS_CORD, LS_FILT1, LS_FILT2, LS_DONE
  } lane_state_t;

  typedef struct packed {
    logic start;
    logic ack;
  } lane_ctrl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } lane_stat_t;

  // atan(2^-i) in degrees, 16 fraction bits, rounded to nearest
  function automatic logic [21:0] atan_q16(input logic [4:0] idx);
    logic [21:0] r;
    begin
      case (idx)
        5'd0:  r = 22'd2949120;
        5'd1:  r = 22'd1740967;
        5'd2:  r = 22'd919879;
        5'd3:  r = 22'd466945;
        5'd4:  r = 22'd234379;
        5'd5:  r = 22'd117304;
        5'd6:  r = 22'd58666;
        5'd7:  r = 22'd29335;
        5'd8:  r = 22'd14668;
        5'd9:  r = 22'd7334;
        5'd10: r = 22'd3667;
        5'd11: r = 22'd1833;
        5'd12: r = 22'd917;
        5'd13: r = 22'd458;
        5'd14: r = 22'd229;
        5'd15: r = 22'd115;
        5'd16: r = 22'd57;
        5'd17: r = 22'd29;
        5'd18: r = 22'd14;
        5'd19: r = 22'd7;
        5'd20: r = 22'd4;
        5'd21: r = 22'd2;
        5'd22: r = 22'd1;
        default: r = 22'd0;
      endcase
      return r;
    end
  endfunction
endpackage

// ----- rtl/tas_lane.sv -----
// One angle lane: squares, digit-recurrence square root, CORDIC vectoring, smoothing filter
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tas_lane #(
  parameter int CORDIC_ITERATIONS = tas_pkg::CordicIterDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tas_pkg::lane_ctrl_t ctrl,
  input  logic signed [15:0]  num,
  input  logic signed [15:0]  u,
  input  logic signed [15:0]  v,
  input  logic [7:0]          weight,
  output tas_pkg::lane_stat_t stat,
  output logic signed [19:0]  filt
);
  import tas_pkg::*;

  localparam int IterW = (CORDIC_ITERATIONS > 1) ? $clog2(CORDIC_ITERATIONS) : 1;

  lane_state_t state_r, state_nxt;
  logic signed [15:0] num_r, u_r, v_r;
  logic [31:0] sq_r;
  logic [47:0] rad_r;
  logic [25:0] rem_r;
  logic [23:0] root_r;
  logic [4:0]  sq_cnt_r;
  logic [IterW-1:0] it_r;
  logic signed [27:0] x_r, y_r;
  logic signed [25:0] z_r;
  logic signed [29:0] mul_r;
  logic signed [19:0] filt_r;

  // square-root digit step
  logic [25:0] rem_sh, trial, rem_new;
  logic [23:0] root_new;
  logic        sqrt_last, cord_last;
  always_comb begin
    rem_sh = {rem_r[23:0], rad_r[47:46]};
    trial  = {root_r, 2'b01};
    if (rem_sh >= trial) begin
      rem_new  = rem_sh - trial;
      root_new = {root_r[22:0], 1'b1};
    end else begin
      rem_new  = rem_sh;
      root_new = {root_r[22:0], 1'b0};
    end
    sqrt_last = (sq_cnt_r == 5'(SqrtSteps - 1));
    cord_last = (it_r == IterW'(CORDIC_ITERATIONS - 1));
  end

  // CORDIC micro-rotation
  logic signed [27:0] xs, ys;
  logic signed [25:0] at;
  always_comb begin
    xs = x_r >>> it_r;
    ys = y_r >>> it_r;
    at = $signed({4'b0, atan_q16(5'(it_r))});
  end

  // filter terms
  logic signed [26:0] z_rnd;
  logic signed [19:0] angle;
  logic signed [9:0]  w_new;
  logic signed [30:0] fsum;
  always_comb begin
    z_rnd = 27'(z_r) + 27'sd8;
    angle = (num_r == 16'sd0) ? 20'sd0 : z_rnd[23:4];
    w_new = $signed(10'd256 - {2'b0, weight});
    fsum  = 31'(mul_r) + 31'(w_new * angle) + 31'sd128;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      LS_IDLE:  if (ctrl.start) state_nxt = LS_SQ1;
      LS_SQ1:   state_nxt = LS_SQ2;
      LS_SQ2:   state_nxt = LS_SQRT;
      LS_SQRT:  if (sqrt_last) state_nxt = LS_CORD;
      LS_CORD:  if (cord_last) state_nxt = LS_FILT1;
      LS_FILT1: state_nxt = LS_FILT2;
      LS_FILT2: state_nxt = LS_DONE;
      LS_DONE:  if (ctrl.ack) state_nxt = LS_IDLE;
      default:  state_nxt = LS_IDLE;
    endcase
  end

  always_comb begin
    stat.idle = (state_r == LS_IDLE);
    stat.done = (state_r == LS_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= LS_IDLE;
      filt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        LS_IDLE: if (ctrl.start) begin
          num_r <= num;
          u_r   <= u;
          v_r   <= v;
        end
        LS_SQ1: sq_r <= 32'(u_r * u_r);
        LS_SQ2: begin
          rad_r    <= {sq_r + 32'(v_r * v_r), 16'b0};
          rem_r    <= '0;
          root_r   <= '0;
          sq_cnt_r <= '0;
        end
        LS_SQRT: begin
          rad_r    <= {rad_r[45:0], 2'b00};
          rem_r    <= rem_new;
          root_r   <= root_new;
          sq_cnt_r <= sq_cnt_r + 5'd1;
          x_r      <= {4'b0, root_new};
          y_r      <= 28'(num_r) <<< 8;
          z_r      <= '0;
          it_r     <= '0;
        end
        LS_CORD: begin
          it_r <= it_r + IterW'(1);
          if (!y_r[27]) begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            z_r <= z_r + at;
          end else begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            z_r <= z_r - at;
          end
        end
        LS_FILT1: mul_r <= 30'($signed({1'b0, weight}) * filt_r);
        LS_FILT2: filt_r <= fsum[27:8];
        default: ;
      endcase
    end
  end

  assign filt = filt_r;

  `ASSERT_CLK(a_start_idle, ctrl.start |-> state_r == LS_IDLE, "lane started while busy")
  `ASSERT_CLK(a_filt_stable, (state_r != LS_FILT2) |=> $stable(filt_r), "filter moved outside update")
endmodule

// ----- rtl/tilt_angle_smoother_core.sv -----
// Top level: two angle lanes, weight register and merged output register
// Input transfer: in_valid high and in_stall low; one sample starts both lanes.
// Lane 0 computes pitch = atan2(x, sqrt(y^2+z^2)), lane 1 roll = atan2(y, sqrt(x^2+z^2)),
// each through the squaring states LS_SQ1 and LS_SQ2, a 24-digit square root and CORDIC_ITERATIONS
// CORDIC micro-rotations, then an exponential filter in states LS_FILT1 and LS_FILT2.
// One sample at a time: in_stall stays high until both lanes have handed their results
// to the output register; a new sample is then taken while the previous result still
// waits. The sequential square root and CORDIC loops in each lane set the sample rate.
// Output register holds pitch_deg and roll_deg (Q7.8 degrees) until out_stall is low.
// A stalled receiver holds finished lanes, and through them in_stall.
// cfg_wr_en writes smoothing_weight (weight of the old filtered angle, /256); write
// only while idle.
// Synchronous reset (rst_n low): weight 205, filtered angles zero, no output valid.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tilt_angle_smoother_core #(
  parameter int CORDIC_ITERATIONS = tas_pkg::CordicIterDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  input  logic signed [15:0] in_accel_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_pitch_deg,
  output logic signed [15:0] out_roll_deg,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data
);
  import tas_pkg::*;

  logic       busy_r, busy_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] weight_r;
  logic signed [15:0] pitch_r, roll_r;
  lane_ctrl_t ctrl;
  lane_stat_t stat_p, stat_r;
  logic signed [19:0] filt_p, filt_q;
  logic in_xfer, both_done, load;
  logic signed [20:0] p_rnd, r_rnd;

  always_comb begin
    in_xfer       = in_valid && !busy_r;
    both_done     = stat_p.done && stat_r.done;
    load          = both_done && (!out_valid_r || !out_stall);
    ctrl.start    = in_xfer;
    ctrl.ack      = load;
    busy_nxt      = in_xfer ? 1'b1 : (load ? 1'b0 : busy_r);
    out_valid_nxt = load ? 1'b1 : (out_valid_r && out_stall);
    p_rnd         = 21'(filt_p) + 21'sd8;
    r_rnd         = 21'(filt_q) + 21'sd8;
  end

  tas_lane #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_pitch (
    .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .num(in_accel_x), .u(in_accel_y),
    .v(in_accel_z), .weight(weight_r), .stat(stat_p), .filt(filt_p)
  );

  tas_lane #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_roll (
    .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .num(in_accel_y), .u(in_accel_x),
    .v(in_accel_z), .weight(weight_r), .stat(stat_r), .filt(filt_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      weight_r    <= 8'(WeightReset);
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) weight_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pitch_r <= p_rnd[19:4];
      roll_r  <= r_rnd[19:4];
    end
  end

  assign in_stall      = busy_r;
  assign out_valid     = out_valid_r;
  assign out_pitch_deg = pitch_r;
  assign out_roll_deg  = roll_r;

  `ASSERT_CLK(a_lanes_lockstep, stat_p.done == stat_r.done, "lanes out of step")
  `ASSERT_CLK(a_load_busy, load |-> busy_r, "result loaded without a sample in flight")
  `ASSERT_NEVER(a_idle_busy, !busy_r && !(stat_p.idle && stat_r.idle), "lanes busy while idle")
endmodule

// ----- tb/sv/tb_tilt_angle_smoother_core.sv -----
// Testbench for the tilt smoother: predicted filtered pitch and roll checked per transfer
`timescale 1ns / 1ps
module tb_tilt_angle_smoother_core;
  import tas_pkg::*;

  localparam int CordicSteps = CordicIterDefault;
  localparam int Latency     = CordicSteps + 31;
  localparam int IdleLimit   = 2000;

  typedef struct {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
  } accel_sample_t;

  typedef struct {
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
  } tilt_pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_accel_x = '0;
  logic signed [15:0] in_accel_y = '0;
  logic signed [15:0] in_accel_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_pitch_deg;
  logic signed [15:0] out_roll_deg;
  logic cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = '0;

  accel_sample_t pending_samples[$];
  tilt_pair_t    expected_tilts[$];
  logic [7:0]    weight_model;
  logic signed [19:0] pitch_state;
  logic signed [19:0] roll_state;
  int  n_errors = 0;
  int  n_samples = 0;
  int  n_results = 0;
  int  idle_cycles = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  bit  quiet_phase = 1'b0;
  bit  in_accepted = 1'b0;

  tilt_angle_smoother_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_accel_x(in_accel_x), .in_accel_y(in_accel_y), .in_accel_z(in_accel_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pitch_deg(out_pitch_deg), .out_roll_deg(out_roll_deg),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint floor_div_pow2(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return longint'(res);
  endfunction

  // angle in degrees, 12 fraction bits
  function automatic longint cordic_tilt(longint num, longint u, longint v);
    longint x, y, z, xs, ys;
    if (num == 0) return 0;
    x = int_sqrt(longint'(u * u + v * v) << 16);
    y = num * 256;
    z = 0;
    for (int i = 0; i < CordicSteps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += longint'(atan_q16(i[4:0]));
      end else begin
        x -= ys; y += xs; z -= longint'(atan_q16(i[4:0]));
      end
    end
    return floor_div_pow2(z + 8, 4);
  endfunction

  function automatic longint ema_update(longint old, longint ang, longint w);
    return floor_div_pow2(w * old + (256 - w) * ang + 128, 8);
  endfunction

  task automatic predict_tilt(accel_sample_t s);
    longint p, r;
    tilt_pair_t t;
    p = cordic_tilt(s.ax, s.ay, s.az);
    r = cordic_tilt(s.ay, s.ax, s.az);
    pitch_state = 20'(ema_update(pitch_state, p, weight_model));
    roll_state  = 20'(ema_update(roll_state, r, weight_model));
    t.pitch = 16'(floor_div_pow2(longint'(pitch_state) + 8, 4));
    t.roll  = 16'(floor_div_pow2(longint'(roll_state) + 8, 4));
    expected_tilts.push_back(t);
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_accepted) begin
        // transfer took place at the last rising edge
        predict_tilt(pending_samples.pop_front());
        n_samples++;
      end
      if (in_accepted || !in_valid) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          if (!quiet_phase && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(1, 9) - 1;
            in_valid <= 1'b0;
          end else begin
            in_valid   <= 1'b1;
            in_accel_x <= pending_samples[0].ax;
            in_accel_y <= pending_samples[0].ay;
            in_accel_z <= pending_samples[0].az;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
      in_accepted = 1'b0;
      if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
        recv_gap = $urandom_range(1, 9) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    tilt_pair_t e;
    if (rst_n) begin
      if (in_valid && !in_stall) in_accepted = 1'b1;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (out_valid && !out_stall) begin
        n_results++;
        if (expected_tilts.size() == 0) begin
          $error("result transfer with nothing expected");
          n_errors++;
        end else begin
          e = expected_tilts.pop_front();
          if (out_pitch_deg !== e.pitch) begin
            $error("pitch_deg expected %0d got %0d", e.pitch, out_pitch_deg);
            n_errors++;
          end
          if (out_roll_deg !== e.roll) begin
            $error("roll_deg expected %0d got %0d", e.roll, out_roll_deg);
            n_errors++;
          end
        end
      end
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no transfer for %0d cycles", IdleLimit);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic logic signed [15:0] rand_axis();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3: return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_sample(logic signed [15:0] x, logic signed [15:0] y,
                              logic signed [15:0] z);
    accel_sample_t s;
    s.ax = x; s.ay = y; s.az = z;
    pending_samples.push_back(s);
  endtask

  task automatic wait_drained();
    while (pending_samples.size() > 0 || expected_tilts.size() > 0 || in_valid)
      @(posedge clk);
    repeat (Latency) @(posedge clk);
  endtask

  task automatic write_weight(logic [7:0] w);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    weight_model = w;
  endtask

  initial begin
    logic [7:0] weights[5] = '{8'd0, 8'd255, 8'd128, 8'd1, 8'd205};
    weight_model = 8'(WeightReset);
    pitch_state = '0;
    roll_state = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: zero numerator, zero denominator, extremes, at reset weight
    queue_sample(0, 0, 0);
    queue_sample(16'sh7fff, 0, 0);
    queue_sample(16'sh8000, 0, 0);
    queue_sample(0, 16'sh7fff, 0);
    queue_sample(0, 16'sh8000, 0);
    queue_sample(0, 0, 16'sh7fff);
    queue_sample(0, 0, 16'sh8000);
    queue_sample(16'sh8000, 16'sh8000, 16'sh8000);
    queue_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
    queue_sample(16'sh7fff, 16'sh8000, 16'sh7fff);
    queue_sample(1, -1, 0);
    queue_sample(-1, 1, 16'sh8000);
    queue_sample(16'sh5555, 16'shaaaa, 16'sh0f0f);
    queue_sample(16'shaaaa, 16'sh5555, 16'shf0f0);
    wait_drained();

    write_weight(8'd0);
    queue_sample(16'sh7fff, 0, 0);
    queue_sample(0, 16'sh8000, 1);
    wait_drained();

    for (int ph = 0; ph < 5; ph++) begin
      write_weight(weights[ph]);
      for (int k = 0; k < 350; k++) begin
        if (ph == 4 && k == 250) quiet_phase = 1'b1;
        queue_sample(rand_axis(), rand_axis(), rand_axis());
      end
      wait_drained();
    end

    $display("covered %0d samples, %0d results, weights 0/1/128/205/255",
             n_samples, n_results);
    if (n_errors == 0 && expected_tilts.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
